>>> rtl/lzss_fbd_pkg.sv
// Shared widths, constants and the window preset pattern for the LZSS decompressor.
`default_nettype none
package lzss_fbd_pkg;

    localparam int WIN_AW     = 12;
    localparam int WIN_DEPTH  = 1 << WIN_AW;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 32;
    localparam int MLEN_W     = 5;
    localparam int LOOKAHEAD  = 18;
    localparam int MIN_MATCH  = 3;

    localparam logic [WIN_AW-1:0] WP_START   = WIN_AW'(WIN_DEPTH - LOOKAHEAD);
    // floor(p / 13) == (p * 5042) >> 16 for every p below 3328
    localparam logic [12:0]       DIV13_MUL  = 13'd5042;
    localparam logic [3:0]        NIB_RAMP   = 4'hD;
    localparam logic [3:0]        NIB_DOWN   = 4'hE;
    localparam logic [3:0]        NIB_TAIL   = 4'hF;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    // Byte held at window address p right after a start.
    function automatic logic [BYTE_W-1:0] preset_byte(input logic [WIN_AW-1:0] p);
        logic [24:0] prod;
        logic [BYTE_W-1:0] res;
        prod = 25'(p) * 25'(DIV13_MUL);
        case (p[11:8])
            NIB_RAMP: res = p[7:0];
            NIB_DOWN: res = ~p[7:0];
            NIB_TAIL: res = p[7] ? SPACE_CHAR : '0;
            default:  res = prod[23:16];
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/lzss_fbd_in_if.sv
// Input channel: command and compressed byte.
`default_nettype none
interface lzss_fbd_in_if;
    import lzss_fbd_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] in_byte;
    modport source (output valid, command, in_byte, input ready);
    modport sink   (input valid, command, in_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/lzss_fbd_out_if.sv
// Output channel: one decompressed byte with run and file markers.
`default_nettype none
interface lzss_fbd_out_if;
    import lzss_fbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              file_done;
    modport source (output valid, out_byte, last_of_run, file_done, input ready);
    modport sink   (input valid, out_byte, last_of_run, file_done, output ready);
endinterface
`default_nettype wire

>>> rtl/lzss_fbd_cfg_if.sv
// Configuration write channel: output length register.
`default_nettype none
interface lzss_fbd_cfg_if;
    import lzss_fbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] output_length;
    modport source (output valid, output_length, input ready);
    modport sink   (input valid, output_length, output ready);
endinterface
`default_nettype wire

>>> rtl/lzss_flag_byte_decompressor.sv
// LZSS flag-byte decompressor with a 4096-byte ring window in one synchronous RAM.
// A literal is registered into the output register on its transfer; match bytes pass
// the window read register, then the output register, and then follow at one byte per
// cycle while the output accepts. Input: one per cycle for flag, literal and first bytes
// while the output slot is free; after a pair's second byte the input waits for the copy.
// Reset and start take effect at once: a fill count marks unwritten window entries,
// which read as the preset pattern, so no clearing pass is run.
`default_nettype none
module lzss_flag_byte_decompressor (
    input  wire            i_clk,
    input  wire            i_rst_n,
    lzss_fbd_cfg_if.sink   i_cfg,
    lzss_fbd_in_if.sink    i_in,
    lzss_fbd_out_if.source o_out
);
    import lzss_fbd_pkg::*;

    typedef enum logic [1:0] {PH_FLAG, PH_FIRST, PH_SECOND} t_phase;
    typedef enum logic {S_IDLE, S_COPY} t_state;

    t_state              r_state;
    t_phase              r_phase;
    logic [BYTE_W-1:0]   r_flag_bits;
    logic [3:0]          r_flags_left;
    logic [BYTE_W-1:0]   r_pending;
    logic [LEN_W-1:0]    r_remaining;
    logic [LEN_W-1:0]    r_out_len;
    logic [WIN_AW-1:0]   r_wp;
    logic [WIN_AW:0]     r_fill;
    logic [WIN_AW-1:0]   r_src;
    logic [MLEN_W-1:0]   r_len;

    logic [BYTE_W-1:0]   r_window [WIN_DEPTH];
    logic [BYTE_W-1:0]   r_rdata;
    logic                r_fwd;
    logic [BYTE_W-1:0]   r_fwd_data;
    logic                r_written;
    logic [BYTE_W-1:0]   r_preset;

    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;
    logic                r_out_done;

    logic                slot_free;
    logic                in_fire;
    logic                data_live;
    logic                rd_en;
    logic [WIN_AW-1:0]   rd_addr;
    logic                wr_en;
    logic                emit;
    logic                emit_last;
    logic [BYTE_W-1:0]   emit_byte;
    logic [BYTE_W-1:0]   copy_byte;
    logic                copy_more;
    logic [WIN_AW-1:0]   pair_src;
    logic [WIN_AW-1:0]   rd_off;
    logic                rd_written;

    assign slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && slot_free;
    assign i_cfg.ready = 1'b1;
    assign in_fire = i_in.valid && i_in.ready;
    assign data_live = in_fire && i_in.command && (r_remaining != '0);
    assign pair_src = {i_in.in_byte[7:4], r_pending};
    assign copy_byte = r_fwd ? r_fwd_data : (r_written ? r_rdata : r_preset);
    assign copy_more = (r_len != MLEN_W'(1)) && (r_remaining != LEN_W'(1));

    // entry was written since the start if it lies within the fill from WP_START
    assign rd_off = rd_addr - WP_START;
    assign rd_written = r_fill[WIN_AW] || (rd_off < r_fill[WIN_AW-1:0]);

    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_src;
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_byte = copy_byte;
        if (data_live) begin
            case (r_phase)
                PH_FIRST: begin
                    if (r_flag_bits[0]) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        emit_byte = i_in.in_byte;
                    end
                end
                PH_SECOND: begin
                    rd_en   = 1'b1;
                    rd_addr = pair_src;
                end
                default: ;
            endcase
        end
        if (r_state == S_COPY && slot_free) begin
            emit      = 1'b1;
            emit_last = !copy_more;
            rd_en     = copy_more;
        end
    end

    assign wr_en = emit;

    // window RAM, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_window[r_wp] <= emit_byte;
        end
        if (rd_en) begin
            r_rdata <= r_window[rd_addr];
        end
    end

    // side data for the pending read: bypass of a same-cycle write, fill test, preset
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_fwd      <= wr_en && (rd_addr == r_wp);
            r_fwd_data <= emit_byte;
            r_written  <= rd_written;
            r_preset   <= preset_byte(rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_FLAG;
            r_flag_bits  <= '0;
            r_flags_left <= '0;
            r_pending    <= '0;
            r_remaining  <= '0;
            r_out_len    <= '0;
            r_wp         <= WP_START;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_out_len <= i_cfg.output_length;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= emit_byte;
                r_out_last  <= emit_last;
                r_out_done  <= (r_remaining == LEN_W'(1));
                r_wp        <= r_wp + WIN_AW'(1);
                r_remaining <= r_remaining - LEN_W'(1);
                if (!r_fill[WIN_AW]) begin
                    r_fill <= r_fill + (WIN_AW+1)'(1);
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_fire && !i_in.command) begin
                r_wp         <= WP_START;
                r_fill       <= '0;
                r_phase      <= PH_FLAG;
                r_flag_bits  <= '0;
                r_flags_left <= '0;
                r_pending    <= '0;
                r_remaining  <= r_out_len;
            end else if (data_live) begin
                unique case (r_phase)
                    PH_FIRST: begin
                        if (r_flag_bits[0]) begin
                            r_flag_bits  <= r_flag_bits >> 1;
                            r_flags_left <= r_flags_left - 4'd1;
                            r_phase      <= (r_flags_left == 4'd1) ? PH_FLAG : PH_FIRST;
                        end else begin
                            r_pending <= i_in.in_byte;
                            r_phase   <= PH_SECOND;
                        end
                    end
                    PH_SECOND: begin
                        r_state <= S_COPY;
                        r_src   <= pair_src + WIN_AW'(1);
                        r_len   <= MLEN_W'(i_in.in_byte[3:0]) + MLEN_W'(MIN_MATCH);
                    end
                    default: begin
                        r_flag_bits  <= i_in.in_byte;
                        r_flags_left <= 4'd8;
                        r_phase      <= PH_FIRST;
                    end
                endcase
            end

            if (r_state == S_COPY && slot_free) begin
                r_src <= r_src + WIN_AW'(1);
                r_len <= r_len - MLEN_W'(1);
                if (!copy_more) begin
                    r_state      <= S_IDLE;
                    r_flag_bits  <= r_flag_bits >> 1;
                    r_flags_left <= r_flags_left - 4'd1;
                    r_phase      <= (r_flags_left == 4'd1) ? PH_FLAG : PH_FIRST;
                end
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;
    assign o_out.file_done   = r_out_done;

endmodule
`default_nettype wire

>>> tb/sv/lzss_flag_byte_decompressor_tb.sv
// Self-checking testbench for the LZSS flag-byte decompressor.
`timescale 1ns / 1ps

module lzss_flag_byte_decompressor_tb;
    import lzss_fbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 25;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_SHOWN   = 10;

    // preset window layout
    localparam int RUN_END   = 256 * 13;
    localparam int UP_END    = RUN_END + 256;
    localparam int DOWN_END  = UP_END + 256;
    localparam int ZERO_END  = DOWN_END + 128;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_e;

    typedef enum logic [1:0] {
        WANT_FLAG  = 2'd0,
        WANT_TOKEN = 2'd1,
        WANT_HIGH  = 2'd2
    } tok_phase_e;

    typedef struct packed {
        cmd_e              command;
        logic [BYTE_W-1:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              file_done;
    } out_res_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid  = 1'b0;
    logic              in_cmd    = CMD_DATA;
    logic [BYTE_W-1:0] in_data   = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [LEN_W-1:0]  cfg_data  = '0;

    lzss_fbd_in_if  in_if ();
    lzss_fbd_out_if out_if ();
    lzss_fbd_cfg_if cfg_if ();

    assign in_if.valid          = in_valid;
    assign in_if.command        = in_cmd;
    assign in_if.in_byte        = in_data;
    assign out_if.ready         = out_ready;
    assign cfg_if.valid         = cfg_valid;
    assign cfg_if.output_length = cfg_data;

    lzss_flag_byte_decompressor dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5ns clk = ~clk;

    // Decoder state mirrored by the predictor
    logic [BYTE_W-1:0] hist_win [WIN_DEPTH];
    logic [WIN_AW-1:0] wr_pos;
    logic [7:0]        flag_reg;
    logic [3:0]        flags_left;
    tok_phase_e        phase;
    logic [7:0]        low_byte;
    logic [LEN_W-1:0]  remaining;
    logic [LEN_W-1:0]  cfg_len;

    in_item_t stream_q [$];
    out_res_t expected_bytes [$];

    int  n_sent      = 0;
    int  n_accepted  = 0;
    int  n_err       = 0;
    int  n_cycles    = 0;
    int  gap_left    = 0;
    int  hold_left   = 0;
    int  holds_asked = 0;
    int  holds_done  = 0;
    bit  no_idle     = 1'b0;
    logic in_taken   = 1'b0;

    // ---------------------------------------------------------------- predictor

    task automatic restart_file();
        int p;
        for (p = 0; p < WIN_DEPTH; p++) begin
            if (p < RUN_END)
                hist_win[p] = 8'(p / 13);
            else if (p < UP_END)
                hist_win[p] = 8'(p - RUN_END);
            else if (p < DOWN_END)
                hist_win[p] = 8'(DOWN_END - 1 - p);
            else if (p < ZERO_END)
                hist_win[p] = 8'h00;
            else
                hist_win[p] = SPACE_CHAR;
        end
        wr_pos     = WP_START;
        flag_reg   = '0;
        flags_left = '0;
        phase      = WANT_FLAG;
        low_byte   = '0;
        remaining  = cfg_len;
    endtask

    task automatic emit_byte(input logic [BYTE_W-1:0] b);
        hist_win[wr_pos] = b;
        wr_pos           = wr_pos + WIN_AW'(1);
        remaining        = remaining - LEN_W'(1);
        expected_bytes.push_back(out_res_t'{b, 1'b0, remaining == 0});
    endtask

    task automatic next_token();
        flag_reg   = flag_reg >> 1;
        flags_left = flags_left - 4'd1;
        phase      = (flags_left == 0) ? WANT_FLAG : WANT_TOKEN;
    endtask

    task automatic decode_item(input logic cmd, input logic [BYTE_W-1:0] b);
        logic [WIN_AW-1:0] src;
        int                len;
        int                n;
        out_res_t          tail;
        n = 0;
        if (cmd == CMD_START) begin
            restart_file();
        end else if (remaining != 0) begin
            case (phase)
                WANT_TOKEN: begin
                    if (flag_reg[0]) begin
                        emit_byte(b);
                        n = 1;
                        next_token();
                    end else begin
                        low_byte = b;
                        phase    = WANT_HIGH;
                    end
                end
                WANT_HIGH: begin
                    src = {b[7:4], low_byte};
                    len = int'(b[3:0]) + MIN_MATCH;
                    // byte-wise copy: source may overlap what is being written
                    while (len != 0 && remaining != 0) begin
                        emit_byte(hist_win[src]);
                        src = src + WIN_AW'(1);
                        len--;
                        n++;
                    end
                    next_token();
                end
                default: begin
                    flag_reg   = b;
                    flags_left = 4'd8;
                    phase      = WANT_TOKEN;
                end
            endcase
            if (n > 0) begin
                tail = expected_bytes.pop_back();
                tail.last_of_run = 1'b1;
                expected_bytes.push_back(tail);
            end
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic int idle_cycles(input int busy_pct);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r >= busy_pct)
            return 0;
        if (r < busy_pct / 8)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    task automatic push_item(input cmd_e c, input logic [BYTE_W-1:0] b);
        stream_q.push_back(in_item_t'{c, b});
    endtask

    // Well-formed token groups with random content, plus the odd restart.
    task automatic queue_stream(input int n_tok, input int lit_pct);
        logic [7:0]        flags;
        logic [WIN_AW-1:0] gen_pos;
        logic [WIN_AW-1:0] pos;
        logic [3:0]        len_code;
        int                grp_left;
        int                k;
        int                j;
        gen_pos  = WP_START;
        grp_left = 0;
        flags    = '0;
        for (k = 0; k < n_tok; k++) begin
            if ($urandom_range(0, 99) < 3) begin
                push_item(CMD_START, 8'($urandom));
                gen_pos  = WP_START;
                grp_left = 0;
            end
            if (grp_left == 0) begin
                for (j = 0; j < 8; j++)
                    flags[j] = ($urandom_range(0, 99) < lit_pct);
                push_item(CMD_DATA, flags);
                grp_left = 8;
            end
            if (flags[0]) begin
                push_item(CMD_DATA, 8'($urandom));
                gen_pos = gen_pos + WIN_AW'(1);
            end else begin
                len_code = 4'($urandom);
                // half the matches point just behind the write position
                if ($urandom_range(0, 1) != 0)
                    pos = gen_pos - WIN_AW'($urandom_range(1, 24));
                else
                    pos = WIN_AW'($urandom);
                push_item(CMD_DATA, pos[7:0]);
                push_item(CMD_DATA, {pos[11:8], len_code});
                gen_pos = gen_pos + WIN_AW'(len_code) + WIN_AW'(MIN_MATCH);
            end
            flags    = flags >> 1;
            grp_left = grp_left - 1;
        end
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_len = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued item is transferred and every byte has come out.
    task automatic settle();
        while (stream_q.size() != 0 || n_sent != n_accepted || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge clk) begin
        in_item_t item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!in_valid || in_taken) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (stream_q.size() != 0) begin
                item = stream_q.pop_front();
                in_valid <= 1'b1;
                in_cmd   <= item.command;
                in_data  <= item.in_byte;
                gap_left <= idle_cycles(30);
                n_sent   <= n_sent + 1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure; a requested long hold lets the block fill and stall its input.
    always @(negedge clk) begin
        int stall;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            out_ready  <= 1'b0;
            hold_left  <= LONG_HOLD - 1;
            holds_done <= holds_done + 1;
        end else begin
            stall = idle_cycles(25);
            out_ready <= (stall == 0);
            if (stall != 0)
                hold_left <= stall - 1;
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic log_fail(input string msg);
        n_err++;
        if (n_err <= MAX_SHOWN)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    always @(posedge clk) begin
        out_res_t want;
        in_taken <= in_if.valid && in_if.ready;
        if (rst_n && in_if.valid && in_if.ready) begin
            decode_item(in_if.command, in_if.in_byte);
            n_accepted <= n_accepted + 1;
        end
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                log_fail($sformatf("unexpected output byte %02h last %0b done %0b",
                                   out_if.out_byte, out_if.last_of_run, out_if.file_done));
            end else begin
                want = expected_bytes.pop_front();
                if (out_if.out_byte !== want.out_byte ||
                    out_if.last_of_run !== want.last_of_run ||
                    out_if.file_done !== want.file_done)
                    log_fail($sformatf({"expected byte %02h last %0b done %0b, ",
                                        "got byte %02h last %0b done %0b"},
                                       want.out_byte, want.last_of_run, want.file_done,
                                       out_if.out_byte, out_if.last_of_run,
                                       out_if.file_done));
            end
        end
    end

    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        logic [LEN_W-1:0] len;
        int               ph;
        int               n_tok;

        cfg_len = '0;
        restart_file();
        remaining = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // data before any start, then a start with the reset length of zero
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'hFF);
        push_item(CMD_DATA, 8'h5A);
        push_item(CMD_START, 8'h00);
        push_item(CMD_DATA, 8'hC3);
        settle();

        // unlimited length: wrapped match, literals, overlapping match
        write_len('1);
        push_item(CMD_START, 8'hFF);
        push_item(CMD_DATA, 8'h7C);
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'hFF);
        push_item(CMD_DATA, 8'hFF);
        push_item(CMD_DATA, 8'hFF);
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'h80);
        push_item(CMD_DATA, 8'h7F);
        push_item(CMD_DATA, 8'h01);
        push_item(CMD_DATA, 8'h07);
        push_item(CMD_DATA, 8'h0F);
        settle();

        // match cut by the file length, then trailing input ignored
        write_len(32'd5);
        push_item(CMD_START, 8'h00);
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'h10);
        push_item(CMD_DATA, 8'h2F);
        push_item(CMD_DATA, 8'hAA);

        for (ph = 0; ph < 7; ph++) begin
            settle();
            case (ph)
                0:       len = '1;
                1:       len = LEN_W'($urandom_range(30, 200));
                2:       len = '0;
                3:       len = LEN_W'($urandom);
                4:       len = 32'd1;
                5:       len = LEN_W'($urandom_range(20, 150));
                default: len = '1;
            endcase
            case (ph)
                2:       n_tok = 4;
                4:       n_tok = 6;
                default: n_tok = 14;
            endcase
            write_len(len);
            no_idle = (ph == 3 || ph == 5);
            if (ph == 0)
                holds_asked++;
            push_item(CMD_START, 8'($urandom));
            queue_stream(n_tok, (ph == 0) ? 80 : 50);
        end
        settle();

        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> lzss_flag_byte_decompressor.f
rtl/lzss_fbd_pkg.sv
rtl/lzss_fbd_in_if.sv
rtl/lzss_fbd_out_if.sv
rtl/lzss_fbd_cfg_if.sv
rtl/lzss_flag_byte_decompressor.sv
tb/sv/lzss_flag_byte_decompressor_tb.sv
